FILE: src/assert_macros.svh
// Assertion macros for the RTL of the filtered-derivative PID block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

FILE: src/pfd_pkg.sv
// Package for the filtered-derivative PID block: register map, configuration
// struct, accumulator operations, sequencer states and steps, saturation helper.
// Depends on nothing.
`default_nettype none

package pfd_pkg;

	localparam int ADDR_W = 5;
	localparam int ERR_W  = 16;
	localparam int SDIF_W = 19;
	localparam int PROD_W = 64;
	localparam int ACC_W  = 66;

	typedef enum logic [2:0] {
		REG_SETPOINT    = 3'd0,
		REG_GAIN_P0     = 3'd1,
		REG_GAIN_P1     = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_FILTER_GAIN = 3'd4,
		REG_FILTER_POLE = 3'd5,
		REG_OUTPUT_MAX  = 3'd6,
		REG_OUTPUT_MIN  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]         setpoint;
		logic signed [31:0] gain_p0;
		logic signed [31:0] gain_p1;
		logic signed [31:0] gain_d;
		logic signed [31:0] filter_gain;
		logic signed [31:0] filter_pole;
		logic [7:0]         output_max;
		logic [7:0]         output_min;
	} cfg_t;

	localparam logic [7:0]  RST_SETPOINT    = 8'd60;
	localparam logic [31:0] RST_GAIN_P0     = 32'h0001_3333;
	localparam logic [31:0] RST_GAIN_P1     = 32'hFFFF_0000;
	localparam logic [31:0] RST_GAIN_D      = 32'h0005_0000;
	localparam logic [31:0] RST_FILTER_GAIN = 32'h0000_5555;
	localparam logic [31:0] RST_FILTER_POLE = 32'hFFFF_AAAB;
	localparam logic [7:0]  RST_OUTPUT_MAX  = 8'd100;
	localparam logic [7:0]  RST_OUTPUT_MIN  = 8'd0;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic    vld;
		acc_op_t op;
	} mac_req_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_CALC
	} state_t;

	localparam logic [3:0] STEP_RAW_D      = 4'd0;
	localparam logic [3:0] STEP_FILT_DPREV = 4'd1;
	localparam logic [3:0] STEP_FILT_FPREV = 4'd2;
	localparam logic [3:0] STEP_FILT_D     = 4'd3;
	localparam logic [3:0] STEP_ACC_DRIVE  = 4'd4;
	localparam logic [3:0] STEP_ACC_E0     = 4'd5;
	localparam logic [3:0] STEP_ACC_E1     = 4'd6;
	localparam logic [3:0] STEP_ACC_F      = 4'd7;
	localparam logic [3:0] STEP_SETTLE     = 4'd8;
	localparam logic [3:0] STEP_FINAL      = 4'd9;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
			r = v[31:0];
		end else if (v[ACC_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/pfd_cfg.sv
// APB-style configuration register file of the filtered-derivative PID block.
// Depends on pfd_pkg for the register map, reset values and configuration struct.
`default_nettype none

module pfd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output pfd_pkg::cfg_t               cfg
);
	import pfd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint    <= RST_SETPOINT;
			cfg_q.gain_p0     <= RST_GAIN_P0;
			cfg_q.gain_p1     <= RST_GAIN_P1;
			cfg_q.gain_d      <= RST_GAIN_D;
			cfg_q.filter_gain <= RST_FILTER_GAIN;
			cfg_q.filter_pole <= RST_FILTER_POLE;
			cfg_q.output_max  <= RST_OUTPUT_MAX;
			cfg_q.output_min  <= RST_OUTPUT_MIN;
		end else if (wr_en) begin
			unique case (idx)
				REG_SETPOINT:    cfg_q.setpoint    <= pwdata[7:0];
				REG_GAIN_P0:     cfg_q.gain_p0     <= pwdata;
				REG_GAIN_P1:     cfg_q.gain_p1     <= pwdata;
				REG_GAIN_D:      cfg_q.gain_d      <= pwdata;
				REG_FILTER_GAIN: cfg_q.filter_gain <= pwdata;
				REG_FILTER_POLE: cfg_q.filter_pole <= pwdata;
				REG_OUTPUT_MAX:  cfg_q.output_max  <= pwdata[7:0];
				REG_OUTPUT_MIN:  cfg_q.output_min  <= pwdata[7:0];
				default:         cfg_q.setpoint    <= cfg_q.setpoint;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SETPOINT:    prdata = {24'd0, cfg_q.setpoint};
			REG_GAIN_P0:     prdata = cfg_q.gain_p0;
			REG_GAIN_P1:     prdata = cfg_q.gain_p1;
			REG_GAIN_D:      prdata = cfg_q.gain_d;
			REG_FILTER_GAIN: prdata = cfg_q.filter_gain;
			REG_FILTER_POLE: prdata = cfg_q.filter_pole;
			REG_OUTPUT_MAX:  prdata = {24'd0, cfg_q.output_max};
			REG_OUTPUT_MIN:  prdata = {24'd0, cfg_q.output_min};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/pfd_mac.sv
// Shared multiply-accumulate unit: a registered 32 x 32 signed product feeding
// a 66-bit accumulator that loads, adds or subtracts. Depends on pfd_pkg.
`default_nettype none

module pfd_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfd_pkg::mac_req_t                 req,
	input  logic signed [31:0]                a,
	input  logic signed [31:0]                b,
	output logic signed [pfd_pkg::ACC_W-1:0]  acc
);
	import pfd_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_req_t                 req_s1;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod_ext = $signed({{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1});
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (req_s1.vld) begin
			case (req_s1.op)
				ACC_LOAD: acc_q <= prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				ACC_SUB:  acc_q <= acc_q - prod_ext;
				default:  acc_q <= acc_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/pid_filtered_derivative.sv
// Incremental PID regulator with a first-order filtered derivative term.
// Each request on the slave stream carries one measured temperature in
// quarter degrees; the block answers with one duty value on the master stream.
// The error, its second difference and all products run through one shared
// 32 x 32 multiply-accumulate unit under a ten-step sequencer.
// The duty appears on m_tvalid in the same cycle that s_tready rises again,
// so a new request is taken only once the last duty is loaded. Eight
// multiply-accumulate operations, issued one per cycle, are followed by a
// settle step while the product register and the accumulator drain, and then
// by the final step, which loads the result into an output register. If the
// receiver stalls with a result still held, the final step waits until that
// register is free. The user must write configuration through the APB port
// only while the block is idle; the block itself does not enforce this.
// Reset restores the register defaults and clears the error history, the
// stored drive and both derivative histories.
// Depends on pfd_pkg, pfd_cfg, pfd_mac and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pid_filtered_derivative (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [13:0] measured_temp
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] duty
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import pfd_pkg::*;

	cfg_t                     cfg;
	state_t                   state_q;
	state_t                   state_d;
	logic [3:0]               step_q;
	mac_req_t                 mac_req;
	logic signed [31:0]       op_a;
	logic signed [31:0]       op_b;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_shift;
	logic                     accept;
	logic                     out_load;
	logic                     d_cap;
	logic                     f_cap;

	logic signed [ERR_W-1:0]  e0_in;
	logic signed [SDIF_W-1:0] sdiff_in;
	logic signed [ERR_W-1:0]  e0_q;
	logic signed [SDIF_W-1:0] sdiff_q;
	logic signed [ERR_W-1:0]  e1_q;
	logic signed [ERR_W-1:0]  e2_q;
	logic signed [31:0]       drive_q;
	logic signed [31:0]       dprev_q;
	logic signed [31:0]       fprev_q;
	logic signed [31:0]       d_q;
	logic signed [31:0]       f_q;
	logic signed [ACC_W-1:0]  lim_hi;
	logic signed [ACC_W-1:0]  lim_lo;
	logic [31:0]              clamp_val;
	logic [7:0]               duty_d;
	logic                     m_tvalid_q;
	logic [7:0]               duty_q;
	logic                     seq_start;
	logic                     lim_ordered;
	logic                     duty_ok;

	pfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.a      (op_a),
		.b      (op_b),
		.acc    (acc)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = duty_q;

	assign e0_in = $signed({6'd0, cfg.setpoint, 2'b00})
		- $signed({{2{s_tdata[13]}}, s_tdata[13:0]});
	assign sdiff_in = $signed({{3{e0_in[ERR_W-1]}}, e0_in})
		- $signed({e1_q[ERR_W-1], e1_q[ERR_W-1], e1_q, 1'b0})
		+ $signed({{3{e2_q[ERR_W-1]}}, e2_q});

	assign acc_shift = acc >>> 16;

	assign lim_hi = $signed({{(ACC_W-24){1'b0}}, cfg.output_max, 16'd0});
	assign lim_lo = $signed({{(ACC_W-24){1'b0}}, cfg.output_min, 16'd0});

	always_comb begin
		if (acc >= lim_hi) begin
			clamp_val = {8'd0, cfg.output_max, 16'd0};
		end else if (acc <= lim_lo) begin
			clamp_val = {8'd0, cfg.output_min, 16'd0};
		end else begin
			clamp_val = acc[31:0];
		end
	end

	assign duty_d = clamp_val[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mac_req.vld = 1'b0;
		mac_req.op  = ACC_LOAD;
		op_a        = 32'sd0;
		op_b        = 32'sd0;
		d_cap       = 1'b0;
		f_cap       = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				case (step_q)
					STEP_RAW_D: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_LOAD;
						op_a        = cfg.gain_d;
						op_b        = $signed({{(32-SDIF_W){sdiff_q[SDIF_W-1]}}, sdiff_q});
					end
					STEP_FILT_DPREV: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_LOAD;
						op_a        = cfg.filter_gain;
						op_b        = dprev_q;
					end
					STEP_FILT_FPREV: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_SUB;
						op_a        = cfg.filter_pole;
						op_b        = fprev_q;
						d_cap       = 1'b1;
					end
					STEP_FILT_D: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_ADD;
						op_a        = cfg.filter_gain;
						op_b        = d_q;
					end
					STEP_ACC_DRIVE: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_LOAD;
						op_a        = drive_q;
						op_b        = 32'sd1;
					end
					STEP_ACC_E0: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_ADD;
						op_a        = cfg.gain_p0;
						op_b        = $signed({{(32-ERR_W){e0_q[ERR_W-1]}}, e0_q});
						f_cap       = 1'b1;
					end
					STEP_ACC_E1: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_ADD;
						op_a        = cfg.gain_p1;
						op_b        = $signed({{(32-ERR_W){e1_q[ERR_W-1]}}, e1_q});
					end
					STEP_ACC_F: begin
						mac_req.vld = 1'b1;
						mac_req.op  = ACC_ADD;
						op_a        = f_q;
						op_b        = 32'sd1;
					end
					STEP_FINAL: begin
						if (!m_tvalid_q || m_tready) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						mac_req.vld = 1'b0;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RAW_D;
		end else if (accept) begin
			step_q <= STEP_RAW_D;
		end else if (state_q == ST_CALC && step_q != STEP_FINAL) begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e0_q    <= e0_in;
			sdiff_q <= sdiff_in;
		end
		if (d_cap) begin
			d_q <= sat32(acc);
		end
		if (f_cap) begin
			f_q <= sat32(acc_shift);
		end
		if (out_load) begin
			duty_q <= duty_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q    <= '0;
			e2_q    <= '0;
			drive_q <= '0;
			dprev_q <= '0;
			fprev_q <= '0;
		end else if (out_load) begin
			e2_q    <= e1_q;
			e1_q    <= e0_q;
			drive_q <= clamp_val;
			dprev_q <= d_q;
			fprev_q <= f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign seq_start   = (state_q == ST_CALC) && (step_q == STEP_RAW_D);
	assign lim_ordered = (cfg.output_min <= cfg.output_max);
	assign duty_ok     = (duty_d >= cfg.output_min) && (duty_d <= cfg.output_max);

	`CHK_NEXT(a_accept_starts_seq, clk, arst_n, accept, seq_start)
	`CHK_IMPLY(a_idle_mac_quiet, clk, arst_n, state_q == ST_IDLE, !mac_req.vld)
	`CHK_IMPLY(a_duty_in_limits, clk, arst_n, out_load && lim_ordered, duty_ok)

endmodule

`default_nettype wire

FILE: bench/pid_filtered_derivative_tb.sv
// Self-checking testbench for the filtered-derivative PID block: temperature requests in,
// duty values out, gains set over APB, each duty checked against an in-bench loop model.
// Depends on pfd_pkg and the pid_filtered_derivative RTL.
`timescale 1ns / 100ps

module pid_filtered_derivative_tb;
	import pfd_pkg::*;

	typedef logic signed [65:0] wide_t;

	typedef struct {
		logic [7:0]         setpoint;
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		logic signed [31:0] kd;
		logic signed [31:0] fgain;
		logic signed [31:0] fpole;
		logic [7:0]         omax;
		logic [7:0]         omin;
	} loop_cfg_t;

	localparam wide_t       S32_TOP        = 66'sd2147483647;
	localparam wide_t       S32_BOT        = -66'sd2147483648;
	localparam logic [13:0] TEMP_MIN       = 14'h2000;
	localparam logic [13:0] TEMP_MAX       = 14'h1FFF;
	localparam int          IDLE_PCT       = 38;
	localparam int          RX_HOLD_CYCLES = 400;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [13:0] measured_temp
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;   // [7:0] duty
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	loop_cfg_t           cfg;
	logic signed [15:0]  err_last;
	logic signed [15:0]  err_prev;
	logic signed [31:0]  drive_acc;
	logic signed [31:0]  deriv_raw_last;
	logic signed [31:0]  deriv_filt_last;

	logic [7:0]          duty_expected[$];
	logic [7:0]          duty_want;
	int                  duty_mismatches;
	bit                  gap_free;
	int                  rx_hold_seq;

	pid_filtered_derivative uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] clip32(input wide_t v);
		if (v > S32_TOP) begin
			return S32_TOP[31:0];
		end
		if (v < S32_BOT) begin
			return S32_BOT[31:0];
		end
		return v[31:0];
	endfunction

	function automatic logic [7:0] predict_duty(input logic [13:0] meas_bits);
		wide_t e0, e1, e2, fsum, acc_sum, hi, lo;
		logic signed [31:0] d, f;
		e0 = wide_t'({1'b0, cfg.setpoint}) * 4 - wide_t'($signed(meas_bits));
		e1 = wide_t'(err_last);
		e2 = wide_t'(err_prev);
		d = clip32(wide_t'(cfg.kd) * (e0 - 2 * e1 + e2));
		fsum = wide_t'(cfg.fgain) * wide_t'(d) + wide_t'(cfg.fgain) * wide_t'(deriv_raw_last)
			- wide_t'(cfg.fpole) * wide_t'(deriv_filt_last);
		f = clip32(fsum >>> 16);
		acc_sum = wide_t'(drive_acc) + wide_t'(cfg.p0) * e0 + wide_t'(cfg.p1) * e1 + wide_t'(f);
		hi = wide_t'({1'b0, cfg.omax}) * 65536;
		lo = wide_t'({1'b0, cfg.omin}) * 65536;
		if (acc_sum >= hi) begin
			acc_sum = hi;
		end else if (acc_sum <= lo) begin
			acc_sum = lo;
		end
		err_prev = err_last;
		err_last = e0[15:0];
		deriv_raw_last = d;
		deriv_filt_last = f;
		drive_acc = acc_sum[31:0];
		return acc_sum[23:16];
	endfunction

	function automatic logic [31:0] pick_gain(input bit wild);
		logic [31:0] g;
		if (wild) begin
			case ($urandom_range(0, 3))
				0: g = 32'h7FFF_FFFF;
				1: g = 32'h8000_0000;
				default: g = $urandom();
			endcase
		end else begin
			g = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
		end
		return g;
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			duty_expected.push_back(predict_duty(s_tdata[13:0]));
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (duty_expected.size() == 0) begin
				duty_mismatches++;
				if (duty_mismatches <= 10) begin
					$display("%0t: duty %0d arrived with no request outstanding", $time, m_tdata);
				end
			end else begin
				duty_want = duty_expected.pop_front();
				if (m_tdata !== duty_want) begin
					duty_mismatches++;
					if (duty_mismatches <= 10) begin
						$display("%0t: duty mismatch, expected %0d, got %0d",
							$time, duty_want, m_tdata);
					end
				end
			end
		end
	end

	initial begin : receiver
		int seen;
		int hold_left;
		seen = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_seq != seen) begin
				seen = rx_hold_seq;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_free) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_temp(input logic [13:0] temp);
		if (!gap_free) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, temp};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (duty_expected.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SETPOINT:    cfg.setpoint = value[7:0];
			REG_GAIN_P0:     cfg.p0 = value;
			REG_GAIN_P1:     cfg.p1 = value;
			REG_GAIN_D:      cfg.kd = value;
			REG_FILTER_GAIN: cfg.fgain = value;
			REG_FILTER_POLE: cfg.fpole = value;
			REG_OUTPUT_MAX:  cfg.omax = value[7:0];
			REG_OUTPUT_MIN:  cfg.omin = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_default_gains();
		send_temp(14'd240);
		send_temp(14'd0);
		send_temp(TEMP_MAX);
		send_temp(TEMP_MIN);
		send_temp(TEMP_MAX);
		send_temp(14'h3FFF);
		send_temp(14'd240);
	endtask

	// Full-scale gains drive the raw derivative, the filter and the accumulator into their
	// limits, with the error at both ends of its range.
	task automatic test_saturation();
		settle_block();
		write_reg(REG_SETPOINT, 32'd255);
		write_reg(REG_GAIN_P0, 32'h7FFF_FFFF);
		write_reg(REG_GAIN_P1, 32'h8000_0000);
		write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
		write_reg(REG_FILTER_GAIN, 32'h7FFF_FFFF);
		write_reg(REG_FILTER_POLE, 32'h8000_0000);
		write_reg(REG_OUTPUT_MAX, 32'd255);
		write_reg(REG_OUTPUT_MIN, 32'd0);
		send_temp(TEMP_MIN);
		send_temp(TEMP_MAX);
		send_temp(TEMP_MIN);
		send_temp(TEMP_MAX);
		settle_block();
		write_reg(REG_SETPOINT, 32'd0);
		send_temp(TEMP_MAX);
		send_temp(TEMP_MIN);
		send_temp(TEMP_MAX);
		settle_block();
		write_reg(REG_GAIN_P0, 32'h8000_0000);
		write_reg(REG_GAIN_P1, 32'h7FFF_FFFF);
		write_reg(REG_GAIN_D, 32'h8000_0000);
		write_reg(REG_FILTER_GAIN, 32'h8000_0000);
		write_reg(REG_FILTER_POLE, 32'h7FFF_FFFF);
		send_temp(TEMP_MIN);
		send_temp(TEMP_MAX);
		send_temp(14'd0);
	endtask

	// Tiny derivative gains leave fractional filter sums, so negative values exercise the
	// rounding towards minus infinity.
	task automatic test_filter_rounding();
		settle_block();
		write_reg(REG_SETPOINT, 32'd60);
		write_reg(REG_GAIN_P0, 32'h0001_0000);
		write_reg(REG_GAIN_P1, 32'hFFFF_0000);
		write_reg(REG_GAIN_D, 32'h0000_0001);
		write_reg(REG_FILTER_GAIN, 32'h0000_5555);
		write_reg(REG_FILTER_POLE, 32'hFFFF_0001);
		send_temp(14'd100);
		send_temp(14'd400);
		send_temp(14'd250);
	endtask

	// The upper limit is tested first, so a minimum above the maximum still yields the
	// maximum once the sum reaches it.
	task automatic test_clamp_order();
		settle_block();
		write_reg(REG_GAIN_D, 32'd0);
		write_reg(REG_FILTER_GAIN, 32'd0);
		write_reg(REG_FILTER_POLE, 32'd0);
		write_reg(REG_OUTPUT_MAX, 32'd50);
		write_reg(REG_OUTPUT_MIN, 32'd200);
		send_temp(14'd0);
		send_temp(TEMP_MAX);
		settle_block();
		write_reg(REG_OUTPUT_MAX, 32'd128);
		write_reg(REG_OUTPUT_MIN, 32'd128);
		send_temp(14'd0);
		settle_block();
		write_reg(REG_OUTPUT_MAX, 32'd0);
		write_reg(REG_OUTPUT_MIN, 32'd255);
		send_temp(TEMP_MAX);
		send_temp(14'd0);
	endtask

	// The receiver holds off while requests keep coming, so the block backs up and stalls
	// its input; the sender then waits until every duty is back.
	task automatic test_backpressure();
		int k;
		settle_block();
		write_reg(REG_SETPOINT, 32'd60);
		write_reg(REG_OUTPUT_MAX, 32'd100);
		write_reg(REG_OUTPUT_MIN, 32'd0);
		write_reg(REG_GAIN_P0, 32'h0001_3333);
		write_reg(REG_GAIN_P1, 32'hFFFF_0000);
		write_reg(REG_GAIN_D, 32'h0005_0000);
		write_reg(REG_FILTER_GAIN, 32'h0000_5555);
		write_reg(REG_FILTER_POLE, 32'hFFFF_AAAB);
		gap_free = 1'b1;
		rx_hold_seq++;
		for (k = 0; k < 30; k++) begin
			send_temp(14'd200 + 14'($urandom_range(0, 80)));
		end
		settle_block();
		gap_free = 1'b0;
	endtask

	task automatic test_random_loop();
		int ph, k, walk, sel;
		bit wild;
		logic [7:0] lim_a, lim_b;
		logic [13:0] temp;
		for (ph = 0; ph < 13; ph++) begin
			wild = (ph % 4 == 3);
			settle_block();
			gap_free = (ph == 0);
			write_reg(REG_SETPOINT, $urandom_range(0, 255));
			write_reg(REG_GAIN_P0, pick_gain(wild));
			write_reg(REG_GAIN_P1, pick_gain(wild));
			write_reg(REG_GAIN_D, pick_gain(wild));
			write_reg(REG_FILTER_GAIN, pick_gain(wild));
			write_reg(REG_FILTER_POLE, pick_gain(wild));
			lim_a = 8'($urandom_range(0, 255));
			lim_b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 4) == 0 || lim_a >= lim_b) begin
				write_reg(REG_OUTPUT_MAX, 32'(lim_a));
				write_reg(REG_OUTPUT_MIN, 32'(lim_b));
			end else begin
				write_reg(REG_OUTPUT_MAX, 32'(lim_b));
				write_reg(REG_OUTPUT_MIN, 32'(lim_a));
			end
			walk = int'(cfg.setpoint) * 4 + int'($urandom_range(0, 160)) - 80;
			for (k = 0; k < 135; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					walk = walk + int'($urandom_range(0, 8)) - 4;
					if (walk > 8191) begin
						walk = 8191;
					end else if (walk < -8192) begin
						walk = -8192;
					end
					temp = walk[13:0];
				end else if (sel < 92) begin
					temp = 14'($urandom_range(0, 16383));
				end else begin
					case ($urandom_range(0, 3))
						0: temp = TEMP_MIN;
						1: temp = TEMP_MAX;
						2: temp = 14'd0;
						default: temp = 14'h3FFF;
					endcase
				end
				send_temp(temp);
			end
		end
		gap_free = 1'b0;
	endtask

	initial begin
		int w;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_free = 1'b0;
		rx_hold_seq = 0;
		duty_mismatches = 0;
		cfg.setpoint = 8'd60;
		cfg.p0 = 32'sd78643;
		cfg.p1 = -32'sd65536;
		cfg.kd = 32'sd327680;
		cfg.fgain = 32'sd21845;
		cfg.fpole = -32'sd21845;
		cfg.omax = 8'd100;
		cfg.omin = 8'd0;
		err_last = '0;
		err_prev = '0;
		drive_acc = '0;
		deriv_raw_last = '0;
		deriv_filt_last = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_gains();
		test_saturation();
		test_filter_rounding();
		test_clamp_order();
		test_backpressure();
		test_random_loop();

		s_tvalid <= 1'b0;
		for (w = 0; w < 20000 && duty_expected.size() != 0; w++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (duty_expected.size() != 0) begin
			$display("%0d duty values never arrived", duty_expected.size());
		end
		if (duty_mismatches == 0 && duty_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/pfd_pkg.sv
src/pfd_cfg.sv
src/pfd_mac.sv
src/pid_filtered_derivative.sv
bench/pid_filtered_derivative_tb.sv
